/* hw/rtl/tb2sbs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tb2sbs_pkg;

    // default frame store geometry
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // field widths
    localparam int PIX_W      = 8;
    localparam int PLANE_W    = 2;
    localparam int DIM_CFG_W  = 11;
    localparam int SKIP_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_LINES     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALVE_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUPLICATE_ROWS = 3'd4;

    // register reset values
    localparam logic [DIM_CFG_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [DIM_CFG_W-1:0] RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [SKIP_W-1:0]    RST_SKIP_LINES   = 9'd0;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    // plane codes
    localparam logic [PLANE_W-1:0] PLANE_LUMA = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_CB   = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_CR   = 2'd2;

endpackage

`default_nettype wire

/* hw/rtl/tb2sbs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tb2sbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/stereo_top_bottom_to_side_by_side_top.sv */
// Top-bottom to side-by-side converter for planar 4:2:0 frames.
// Input stream: each word carries an operation in s_tuser and a byte in s_tdata.
// A load word writes the byte into the frame store (luma, then both chroma
// planes, dense); the load address wraps to zero after the last byte of a frame.
// An emit word produces one output byte on the m_ stream: plane in m_tuser,
// m_tlast on the last byte of the side-by-side frame. Emit words give no
// output when the skip count reaches half the luma height.
// Sequencing: load words are accepted back to back while idle. An emit word
// steps through a row address multiply, the address add, two reads of the
// single-port frame store and the pair average (the first byte alone when
// halving is off), then loads the m_ output register; no new word is taken
// until it is done. The output register lets load words be accepted while a
// result waits; an emit word waits in its last step while an earlier result
// is held with m_tready low. Configuration writes (cfg_valid/cfg_ready,
// always ready) restart loading and readout at frame start; s_tready stays
// low until the geometry registers have settled, as it does after reset.
// Reset (aresetn low, synchronous) restores the default registers and clears
// the output valid; frame store contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module stereo_top_bottom_to_side_by_side_top #(
    parameter int MAX_WIDTH  = tb2sbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tb2sbs_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [tb2sbs_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel_in
    input  wire logic [0:0]                         s_tuser,   // [0] operation
    // output stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [tb2sbs_pkg::PIX_W-1:0]       m_tdata,   // [7:0] pixel_out
    output logic      [tb2sbs_pkg::PLANE_W-1:0]     m_tuser,   // [1:0] plane_index
    output logic                                    m_tlast,   // frame_end
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tb2sbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tb2sbs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import tb2sbs_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int SKW   = ((HW > SKIP_W) ? HW : SKIP_W) + 1;
    localparam int PRW   = RW + DW;
    localparam int CMPW  = DW + 1;
    localparam int RCW   = HW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADR  = 3'd2;
    localparam logic [2:0] ST_RDA  = 3'd3;
    localparam logic [2:0] ST_RDB  = 3'd4;
    localparam logic [2:0] ST_SUM  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam logic [1:0] GEO_SETTLE = 2'd3;

    // control state
    logic [2:0]           state_reg;
    logic [1:0]           geo_cnt_reg;
    logic [AW-1:0]        load_addr_reg;
    logic [PLANE_W-1:0]   plane_reg;
    logic [RW-1:0]        row_reg;
    logic [CW-1:0]        col_reg;
    logic                 side_reg;
    logic                 rep_reg;
    logic                 m_tvalid_reg;

    // configuration registers
    logic [DIM_CFG_W-1:0] width_cfg_reg;
    logic [DIM_CFG_W-1:0] height_cfg_reg;
    logic [SKIP_W-1:0]    skip_cfg_reg;
    logic                 halve_reg;
    logic                 dup_reg;

    // geometry registers
    logic [31:0]          t_w;
    logic [31:0]          t_h;
    logic [DW-1:0]        eff_w_next;
    logic [HW-1:0]        eff_h_next;
    logic [DW-1:0]        eff_w_reg;
    logic [HW-1:0]        eff_h_reg;
    logic [DW+HW-1:0]     wh_full;
    logic [AW-1:0]        wh_reg;
    logic [AW-1:0]        base2_reg;
    logic [AW:0]          size_reg;

    // datapath registers
    logic [PRW-1:0]       prod_reg;
    logic [AW-1:0]        colbase_reg;
    logic [AW-1:0]        addr_reg;
    logic [PIX_W-1:0]     a_reg;
    logic [PIX_W-1:0]     pix_reg;
    logic [PIX_W-1:0]     m_tdata_reg;
    logic [PLANE_W-1:0]   m_tuser_reg;
    logic                 m_tlast_reg;

    // per plane geometry
    logic [DW-1:0]        pw;
    logic [HW-1:0]        half;
    logic [SKIP_W-1:0]    sk;
    logic [HW-1:0]        rows;
    logic [SKW-1:0]       off;
    logic [DW-1:0]        sidew;
    logic [AW-1:0]        base;
    logic                 luma_empty;

    logic [SKW-1:0]       srow_wide;
    logic [RW-1:0]        srow;
    logic [PRW-1:0]       prod_full;
    logic [CW:0]          coloff;
    logic [PIX_W:0]       pair_sum;

    logic                 s_accept;
    logic                 out_free;
    logic                 col_last;
    logic                 row_last;

    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [PIX_W-1:0]     ram_rdata;

    // clamp dimensions to [4, max] and round down to a multiple of four
    always_comb begin
        t_w = 32'(width_cfg_reg);
        if (t_w < 32'd4) begin
            t_w = 32'd4;
        end
        if (t_w > 32'(MAX_WIDTH)) begin
            t_w = 32'(MAX_WIDTH);
        end
        t_w = t_w & ~32'd3;
        t_h = 32'(height_cfg_reg);
        if (t_h < 32'd4) begin
            t_h = 32'd4;
        end
        if (t_h > 32'(MAX_HEIGHT)) begin
            t_h = 32'(MAX_HEIGHT);
        end
        t_h = t_h & ~32'd3;
        eff_w_next = DW'(t_w);
        eff_h_next = HW'(t_h);
    end

    assign wh_full = eff_w_reg * eff_h_reg;

    // geometry of the plane being read
    always_comb begin
        if (plane_reg == PLANE_LUMA) begin
            pw   = eff_w_reg;
            half = eff_h_reg >> 1;
            sk   = skip_cfg_reg;
            base = '0;
        end else begin
            pw   = eff_w_reg >> 1;
            half = eff_h_reg >> 2;
            sk   = skip_cfg_reg >> 1;
            base = (plane_reg == PLANE_CB) ? wh_reg : base2_reg;
        end
        rows  = (SKW'(half) > SKW'(sk)) ? HW'(SKW'(half) - SKW'(sk)) : '0;
        off   = SKW'(half) + SKW'(sk);
        sidew = halve_reg ? (pw >> 1) : pw;
    end

    assign luma_empty = !(SKW'(eff_h_reg >> 1) > SKW'(skip_cfg_reg));

    // source address pieces
    assign srow_wide = SKW'(row_reg) + (side_reg ? off : '0);
    assign srow      = RW'(srow_wide);
    assign prod_full = PRW'(srow) * PRW'(pw);
    assign coloff    = halve_reg ? {col_reg, 1'b0} : {1'b0, col_reg};
    assign pair_sum  = {1'b0, a_reg} + {1'b0, ram_rdata};

    // readout position bookkeeping
    assign col_last = (CMPW'(col_reg) + CMPW'(1)) == CMPW'(sidew);
    assign row_last = (RCW'(row_reg) + RCW'(1)) == RCW'(rows);

    assign s_tready = (state_reg == ST_IDLE) && (geo_cnt_reg == '0);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // frame store port
    always_comb begin
        ram_we   = s_accept && (s_tuser[0] == OP_LOAD);
        ram_addr = load_addr_reg;
        case (state_reg)
            ST_RDA:  ram_addr = addr_reg;
            ST_RDB:  ram_addr = addr_reg + AW'(1);
            default: ram_addr = load_addr_reg;
        endcase
    end

    tb2sbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_tdata),
        .rdata (ram_rdata)
    );

    // control: sequencer, counters, registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            geo_cnt_reg    <= GEO_SETTLE;
            load_addr_reg  <= '0;
            plane_reg      <= PLANE_LUMA;
            row_reg        <= '0;
            col_reg        <= '0;
            side_reg       <= 1'b0;
            rep_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            width_cfg_reg  <= RST_FRAME_WIDTH;
            height_cfg_reg <= RST_FRAME_HEIGHT;
            skip_cfg_reg   <= RST_SKIP_LINES;
            halve_reg      <= 1'b1;
            dup_reg        <= 1'b0;
        end else begin
            if (geo_cnt_reg != '0) begin
                geo_cnt_reg <= geo_cnt_reg - 2'd1;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (s_tuser[0] == OP_LOAD) begin
                            if ({1'b0, load_addr_reg} + (AW+1)'(1) >= size_reg) begin
                                load_addr_reg <= '0;
                            end else begin
                                load_addr_reg <= load_addr_reg + AW'(1);
                            end
                        end else if (!luma_empty) begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: state_reg <= ST_ADR;
                ST_ADR: state_reg <= ST_RDA;
                ST_RDA: state_reg <= ST_RDB;
                ST_RDB: state_reg <= ST_SUM;
                ST_SUM: state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                        if (col_last) begin
                            col_reg <= '0;
                            if (!side_reg) begin
                                side_reg <= 1'b1;
                            end else begin
                                side_reg <= 1'b0;
                                if (dup_reg && !rep_reg) begin
                                    rep_reg <= 1'b1;
                                end else begin
                                    rep_reg <= 1'b0;
                                    if (row_last) begin
                                        row_reg <= '0;
                                        if (plane_reg == PLANE_CR) begin
                                            plane_reg <= PLANE_LUMA;
                                        end else begin
                                            plane_reg <= plane_reg + PLANE_W'(1);
                                        end
                                    end else begin
                                        row_reg <= row_reg + RW'(1);
                                    end
                                end
                            end
                        end else begin
                            col_reg <= col_reg + CW'(1);
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            // register writes restart the frame
            if (cfg_valid) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:    width_cfg_reg  <= cfg_data;
                    REG_FRAME_HEIGHT:   height_cfg_reg <= cfg_data;
                    REG_SKIP_LINES:     skip_cfg_reg   <= cfg_data[SKIP_W-1:0];
                    REG_HALVE_WIDTH:    halve_reg      <= cfg_data[0];
                    REG_DUPLICATE_ROWS: dup_reg        <= cfg_data[0];
                    default: ;
                endcase
                if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT ||
                    cfg_index == REG_SKIP_LINES || cfg_index == REG_HALVE_WIDTH ||
                    cfg_index == REG_DUPLICATE_ROWS) begin
                    geo_cnt_reg   <= GEO_SETTLE;
                    load_addr_reg <= '0;
                    plane_reg     <= PLANE_LUMA;
                    row_reg       <= '0;
                    col_reg       <= '0;
                    side_reg      <= 1'b0;
                    rep_reg       <= 1'b0;
                end
            end
        end
    end

    // datapath: geometry pipeline, address build, averaging, output word
    always_ff @(posedge aclk) begin
        eff_w_reg <= eff_w_next;
        eff_h_reg <= eff_h_next;
        wh_reg    <= AW'(wh_full);
        base2_reg <= wh_reg + (wh_reg >> 2);
        size_reg  <= {1'b0, wh_reg} + (AW+1)'(wh_reg >> 1);

        if (state_reg == ST_MUL) begin
            prod_reg    <= prod_full;
            colbase_reg <= base + AW'(coloff);
        end
        if (state_reg == ST_ADR) begin
            addr_reg <= colbase_reg + AW'(prod_reg);
        end
        if (state_reg == ST_RDB) begin
            a_reg <= ram_rdata;
        end
        if (state_reg == ST_SUM) begin
            pix_reg <= halve_reg ? pair_sum[PIX_W:1] : a_reg;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= pix_reg;
            m_tuser_reg <= plane_reg;
            m_tlast_reg <= col_last && side_reg && !(dup_reg && !rep_reg) && row_last &&
                           (plane_reg == PLANE_CR);
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

/* hw/rtl/tb2sbs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module tb2sbs_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic [0:0]                         s_tuser,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [tb2sbs_pkg::PIX_W-1:0]       m_tdata,
    input wire logic [tb2sbs_pkg::PLANE_W-1:0]     m_tuser,
    input wire logic                               m_tlast
);

    import tb2sbs_pkg::*;

    // reset leaves no output word pending
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // frame end falls on the second chroma plane only
    a_end_on_last_plane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == PLANE_CR)
        else $error("frame end outside last plane");

    // a load word never produces an output word
    a_load_no_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == OP_LOAD && !m_tvalid |=> !m_tvalid)
        else $error("output after load word");

    // a stalled output word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
        $stable(m_tlast))
        else $error("output word changed while stalled");

endmodule

bind stereo_top_bottom_to_side_by_side_top tb2sbs_checker u_tb2sbs_checker (.*);

`default_nettype wire
